@@ rtl/jrlsc_pkg.sv @@
// Package: shared widths, symbol codes and the result record of the run-length symbol coder.
`default_nettype none

package jrlsc_pkg;

  // Field widths
  localparam int unsigned CoefW  = 12;
  localparam int unsigned DiffW  = CoefW + 1;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CompW  = 2;
  localparam int unsigned SymW   = 8;
  localparam int unsigned BitsW  = 13;
  localparam int unsigned LenW   = 4;
  localparam int unsigned RunW   = 6;

  // Block geometry and defaults
  localparam int unsigned Components  = 4;
  localparam int unsigned BlockCoefs  = 64;
  localparam logic [PosW-1:0] DcPos   = '0;
  localparam logic [PosW-1:0] LastPos = PosW'(BlockCoefs - 1);

  // Symbol codes
  localparam logic [SymW-1:0] SymZrl = 8'hF0;
  localparam logic [SymW-1:0] SymEob = 8'h00;
  localparam logic [RunW-1:0] RunSat = '1;

  // One result record
  typedef struct packed {
    logic [SymW-1:0]  code_symbol;
    logic             dc_table;
    logic [BitsW-1:0] extra_bits;
    logic [LenW-1:0]  extra_len;
    logic [CompW-1:0] symbol_component;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/jrlsc_value_enc.sv @@
// Size category and ones'-complement extra bits of a signed value.
`default_nettype none

module jrlsc_value_enc (
  input  logic signed [jrlsc_pkg::DiffW-1:0] value_i,
  output logic        [jrlsc_pkg::LenW-1:0]  size_o,
  output logic        [jrlsc_pkg::BitsW-1:0] bits_o
);
  import jrlsc_pkg::*;

  logic [DiffW-1:0] mag;
  logic [DiffW-1:0] raw;
  logic [BitsW-1:0] mask;

  // Take the magnitude and the biased form of a negative value
  assign mag = value_i[DiffW-1] ? DiffW'(-value_i) : DiffW'(value_i);
  assign raw = value_i[DiffW-1] ? DiffW'(value_i - DiffW'(1)) : DiffW'(value_i);

  // Find the position of the highest set magnitude bit
  always_comb begin
    size_o = '0;
    for (int i = 0; i < DiffW; i++) begin
      if (mag[i]) size_o = LenW'(i + 1);
    end
  end

  // Keep the low size bits
  assign mask   = (BitsW'(1) << size_o) - BitsW'(1);
  assign bits_o = BitsW'(raw) & mask;

endmodule

`default_nettype wire

@@ rtl/jrlsc_out_reg.sv @@
// Output register stage that holds one result until the consumer takes it.
`default_nettype none

module jrlsc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jrlsc_pkg::result_t  result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jrlsc_pkg::result_t  result_o
);
  import jrlsc_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  // Load the payload
  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

`default_nettype wire

@@ rtl/jrlsc_core.sv @@
// Item register, DC predictors, zero-run counter and symbol sequencer.
`default_nettype none

module jrlsc_core #(
  parameter int unsigned COMPONENTS = jrlsc_pkg::Components
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [jrlsc_pkg::CoefW-1:0] coefficient_i,
  input  logic        [jrlsc_pkg::PosW-1:0]  position_i,
  input  logic        [jrlsc_pkg::CompW-1:0] component_i,
  input  logic                              restart_i,
  input  logic                              free_i,
  output logic                              push_o,
  output jrlsc_pkg::result_t                result_o,
  output logic                              consume_o,
  output logic                              item_dc_o,
  output logic        [jrlsc_pkg::RunW-1:0]  zero_run_o,
  output logic        [1:0]                 idx_o
);
  import jrlsc_pkg::*;

  localparam int unsigned IdxW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // Item register
  logic                    vld_q;
  logic signed [CoefW-1:0] coef_q;
  logic [PosW-1:0]         pos_q;
  logic [CompW-1:0]        comp_q;
  logic                    rst_q;

  // Block state
  logic signed [CoefW-1:0] pred_q [COMPONENTS];
  logic [RunW-1:0]         zero_run_q;
  logic [RunW-1:0]         zero_run_d;
  logic [1:0]              idx_q;

  logic [CompW-1:0]        comp_sel;
  logic [IdxW-1:0]         pred_idx;
  logic signed [CoefW-1:0] pred_cur;
  logic signed [DiffW-1:0] enc_value;
  logic [LenW-1:0]         enc_size;
  logic [BitsW-1:0]        enc_bits;
  logic                    is_dc;
  logic                    is_zero;
  logic                    no_result;
  logic [1:0]              zrl_cnt;
  logic                    at_last;
  logic                    accept;

  // Clamp the component to the last configured one
  assign comp_sel = ({1'b0, comp_q} >= (CompW + 1)'(COMPONENTS)) ? CompW'(COMPONENTS - 1)
                                                                 : comp_q;
  assign pred_idx = IdxW'(comp_sel);
  assign pred_cur = rst_q ? '0 : pred_q[pred_idx];

  assign is_dc     = (pos_q == DcPos);
  assign is_zero   = (coef_q == '0);
  assign no_result = !is_dc && is_zero && (pos_q != LastPos);
  // One ZRL per sixteen zeros of the run
  assign zrl_cnt   = (!is_dc && !is_zero) ? zero_run_q[RunW-1:4] : 2'd0;
  assign at_last   = (idx_q == zrl_cnt);

  // Encode either the DC difference or the AC coefficient
  assign enc_value = is_dc ? DiffW'(DiffW'(coef_q) - DiffW'(pred_cur)) : DiffW'(coef_q);

  jrlsc_value_enc u_enc (
    .value_i (enc_value),
    .size_o  (enc_size),
    .bits_o  (enc_bits)
  );

  // Handshake toward the item register and the output stage
  assign push_o     = vld_q && !no_result && free_i;
  assign consume_o  = vld_q && (no_result || (free_i && at_last));
  assign in_stall_o = vld_q && !consume_o;
  assign accept     = in_valid_i && !in_stall_o;

  // Build the result at the current sequencer step
  always_comb begin
    result_o                  = '0;
    result_o.symbol_component = comp_sel;
    result_o.last             = at_last;
    priority if (is_dc) begin
      result_o.code_symbol = SymW'(enc_size);
      result_o.dc_table    = 1'b1;
      result_o.extra_bits  = enc_bits;
      result_o.extra_len   = enc_size;
    end else if (is_zero) begin
      result_o.code_symbol = SymEob;
    end else if (!at_last) begin
      result_o.code_symbol = SymZrl;
    end else begin
      result_o.code_symbol = {zero_run_q[3:0], enc_size};
      result_o.extra_bits  = enc_bits;
      result_o.extra_len   = enc_size;
    end
  end

  // Next zero run after this item
  always_comb begin
    zero_run_d = zero_run_q;
    priority if (is_dc || !is_zero || pos_q == LastPos) begin
      zero_run_d = '0;
    end else if (zero_run_q != RunSat) begin
      zero_run_d = zero_run_q + RunW'(1);
    end
  end

  // Load the item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (consume_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      coef_q <= coefficient_i;
      pos_q  <= position_i;
      comp_q <= component_i;
      rst_q  <= restart_i;
    end
  end

  // Advance the sequencer, wrap on the last result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (push_o) begin
      idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Update zero run and predictors when the item retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      for (int i = 0; i < COMPONENTS; i++) pred_q[i] <= '0;
    end else if (consume_o) begin
      zero_run_q <= zero_run_d;
      for (int i = 0; i < COMPONENTS; i++) begin
        if (is_dc && pred_idx == IdxW'(i)) begin
          pred_q[i] <= coef_q;
        end else if (rst_q) begin
          pred_q[i] <= '0;
        end
      end
    end
  end

  assign item_dc_o  = is_dc;
  assign zero_run_o = zero_run_q;
  assign idx_o      = idx_q;

endmodule

`default_nettype wire

@@ rtl/jpeg_run_length_symbol_coder_core.sv @@
// Top level of the baseline JPEG run-length symbol coder.
// Takes one zigzag-ordered quantized coefficient per request and emits the Huffman symbols it
// causes: a DC size symbol for position 0 (coded against the component's predictor, cleared
// by restart), nothing for an inner zero AC coefficient, EOB for a zero at position 63, and
// up to three ZRL symbols followed by a run/size symbol for a nonzero AC coefficient. Each
// result carries its extra bits, their length, the component and a last flag. Throughput is
// one coefficient per cycle while each coefficient yields at most one result and the output
// is not stalled; a coefficient that yields more than one result holds the symbol sequencer
// until its last result is pushed, and the sequencer writes one result per cycle into the
// output register while the output is not stalled. The first result of a request passes the
// item register, then the output register.
`default_nettype none

module jpeg_run_length_symbol_coder_core #(
  parameter int unsigned COMPONENTS = jrlsc_pkg::Components
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [jrlsc_pkg::CoefW-1:0] coefficient_i,
  input  logic        [jrlsc_pkg::PosW-1:0]  position_i,
  input  logic        [jrlsc_pkg::CompW-1:0] component_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic        [jrlsc_pkg::SymW-1:0]  code_symbol_o,
  output logic                              dc_table_o,
  output logic        [jrlsc_pkg::BitsW-1:0] extra_bits_o,
  output logic        [jrlsc_pkg::LenW-1:0]  extra_len_o,
  output logic        [jrlsc_pkg::CompW-1:0] symbol_component_o,
  output logic                              last_o
);
  import jrlsc_pkg::*;

  logic            free;
  logic            push;
  logic            consume;
  logic            item_dc;
  logic [RunW-1:0] zero_run;
  logic [1:0]      idx;
  result_t         core_result;
  result_t         out_result;

  // Symbol sequencer and block state
  jrlsc_core #(
    .COMPONENTS (COMPONENTS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .coefficient_i (coefficient_i),
    .position_i    (position_i),
    .component_i   (component_i),
    .restart_i     (restart_i),
    .free_i        (free),
    .push_o        (push),
    .result_o      (core_result),
    .consume_o     (consume),
    .item_dc_o     (item_dc),
    .zero_run_o    (zero_run),
    .idx_o         (idx)
  );

  // Output register
  jrlsc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (core_result),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign code_symbol_o      = out_result.code_symbol;
  assign dc_table_o         = out_result.dc_table;
  assign extra_bits_o       = out_result.extra_bits;
  assign extra_len_o        = out_result.extra_len;
  assign symbol_component_o = out_result.symbol_component;
  assign last_o             = out_result.last;

`ifndef SYNTHESIS
  // A DC symbol is always the only result of its item
  a_dc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dc_table_o) |-> last_o)
    else $error("DC symbol without last flag");

  // ZRL symbols carry no extra bits
  a_zrl_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !dc_table_o && code_symbol_o == SymZrl) |-> (extra_len_o == '0))
    else $error("ZRL symbol with extra bits");

  // A retired DC item leaves an empty zero run
  a_dc_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && item_dc) |=> (zero_run == '0))
    else $error("zero run not cleared by DC item");

  // While the sequencer is mid-item, the input stays stalled unless a result is pushed
  a_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx != 2'd0) |-> (in_stall_o || push))
    else $error("sequencer left mid-item while accepting");
`endif

endmodule

`default_nettype wire

@@ dv/symbol_stream_checker.sv @@
// Checker: predicts the symbols of each coefficient request and compares them with the coder output.
`default_nettype none

module symbol_stream_checker #(
  parameter int unsigned COMPONENTS = jrlsc_pkg::Components
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [jrlsc_pkg::CoefW-1:0] coefficient_i,
  input  logic        [jrlsc_pkg::PosW-1:0]  position_i,
  input  logic        [jrlsc_pkg::CompW-1:0] component_i,
  input  logic                               restart_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic        [jrlsc_pkg::SymW-1:0]  code_symbol_i,
  input  logic                               dc_table_i,
  input  logic        [jrlsc_pkg::BitsW-1:0] extra_bits_i,
  input  logic        [jrlsc_pkg::LenW-1:0]  extra_len_i,
  input  logic        [jrlsc_pkg::CompW-1:0] symbol_component_i,
  input  logic                               last_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import jrlsc_pkg::*;

  localparam int unsigned RunMax = 15;
  localparam int unsigned RunZrl = 16;
  localparam int unsigned ReportMax = 10;

  // Predicted coder state and the symbols still owed by the coder
  logic signed [CoefW-1:0] dc_pred [COMPONENTS] = '{default: '0};
  logic [RunW-1:0] zero_run = '0;
  result_t symbol_q [$];

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  // Size category and masked ones'-complement extra bits of a signed value
  function automatic void value_code(input int value, output logic [LenW-1:0] size,
                                     output logic [BitsW-1:0] bits);
    int unsigned mag;
    int unsigned raw;
    mag = (value < 0) ? -value : value;
    size = '0;
    while (mag != 0) begin
      size++;
      mag >>= 1;
    end
    raw = (value < 0) ? value - 1 : value;
    bits = (size == 0) ? '0 : BitsW'(raw & ((1 << size) - 1));
  endfunction

  function automatic void add_symbol(logic [SymW-1:0] sym, logic dc, logic [BitsW-1:0] bits,
                                     logic [LenW-1:0] len, int unsigned comp);
    result_t r;
    r.code_symbol = sym;
    r.dc_table = dc;
    r.extra_bits = bits;
    r.extra_len = len;
    r.symbol_component = CompW'(comp);
    r.last = 1'b0;
    symbol_q.push_back(r);
  endfunction

  // Work out every symbol that one coefficient request causes
  function automatic void predict_request(logic signed [CoefW-1:0] coef, logic [PosW-1:0] pos,
                                          logic [CompW-1:0] comp_in, logic restart);
    int unsigned comp;
    int unsigned first;
    int diff;
    logic [LenW-1:0] size;
    logic [BitsW-1:0] bits;
    result_t tail;
    comp = (comp_in >= COMPONENTS) ? COMPONENTS - 1 : comp_in;
    first = symbol_q.size();
    if (restart) begin
      foreach (dc_pred[i]) dc_pred[i] = '0;
    end
    if (pos == DcPos) begin
      diff = int'(coef) - int'(dc_pred[comp]);
      dc_pred[comp] = coef;
      zero_run = '0;
      value_code(diff, size, bits);
      add_symbol(SymW'(size), 1'b1, bits, size, comp);
    end else if (coef == 0) begin
      if (zero_run != RunSat) zero_run++;
      if (pos == LastPos) begin
        add_symbol(SymEob, 1'b0, '0, '0, comp);
        zero_run = '0;
      end
    end else begin
      // Spend the run in ZRL symbols until it fits the run nibble
      while (zero_run > RunMax) begin
        add_symbol(SymZrl, 1'b0, '0, '0, comp);
        zero_run -= RunW'(RunZrl);
      end
      value_code(int'(coef), size, bits);
      add_symbol({zero_run[3:0], size}, 1'b0, bits, size, comp);
      zero_run = '0;
    end
    // Flag the final symbol of this request
    if (symbol_q.size() > first) begin
      tail = symbol_q.pop_back();
      tail.last = 1'b1;
      symbol_q.push_back(tail);
    end
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= ReportMax) begin
      $display("[%0t] %s: expected sym=%02h dc=%0d bits=%04h len=%0d comp=%0d last=%0d",
               $time, what, want.code_symbol, want.dc_table, want.extra_bits,
               want.extra_len, want.symbol_component, want.last);
      $display("        got      sym=%02h dc=%0d bits=%04h len=%0d comp=%0d last=%0d",
               got.code_symbol, got.dc_table, got.extra_bits, got.extra_len,
               got.symbol_component, got.last);
    end
  endfunction

  // Compare one accepted symbol with the oldest prediction
  function automatic void check_symbol(result_t got);
    result_t want;
    if (symbol_q.size() == 0) begin
      note_mismatch("symbol with none expected", '0, got);
      return;
    end
    want = symbol_q.pop_front();
    if (got.code_symbol !== want.code_symbol || got.dc_table !== want.dc_table ||
        got.extra_bits !== want.extra_bits || got.extra_len !== want.extra_len ||
        got.symbol_component !== want.symbol_component || got.last !== want.last) begin
      note_mismatch("symbol mismatch", want, got);
    end
  endfunction

  // Watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (dc_pred[i]) dc_pred[i] = '0;
      zero_run = '0;
      symbol_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_symbol({code_symbol_i, dc_table_i, extra_bits_i, extra_len_i,
                      symbol_component_i, last_i});
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(coefficient_i, position_i, component_i, restart_i);
      end
      pending_o = symbol_q.size();
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench top: drives coefficient requests into the symbol coder and gives the verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jrlsc_pkg::*;

  localparam int unsigned PhaseItems = 20;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CoefW-1:0] coefficient = '0;
  logic [PosW-1:0] position = '0;
  logic [CompW-1:0] component = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SymW-1:0] code_symbol;
  logic dc_table;
  logic [BitsW-1:0] extra_bits;
  logic [LenW-1:0] extra_len;
  logic [CompW-1:0] symbol_component;
  logic last;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned hold_left = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;

  jpeg_run_length_symbol_coder_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .coefficient_i     (coefficient),
    .position_i        (position),
    .component_i       (component),
    .restart_i         (restart),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .code_symbol_o     (code_symbol),
    .dc_table_o        (dc_table),
    .extra_bits_o      (extra_bits),
    .extra_len_o       (extra_len),
    .symbol_component_o(symbol_component),
    .last_o            (last)
  );

  symbol_stream_checker checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .coefficient_i     (coefficient),
    .position_i        (position),
    .component_i       (component),
    .restart_i         (restart),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .code_symbol_i     (code_symbol),
    .dc_table_i        (dc_table),
    .extra_bits_i      (extra_bits),
    .extra_len_i       (extra_len),
    .symbol_component_i(symbol_component),
    .last_i            (last),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("** jpeg_run_length_symbol_coder_core: FAILED **");
    $finish;
  end

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done && hold_left == 0) begin
        hold_left = HoldCycles;
        long_hold_done <= 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_coef(input int coef, input int pos, input int comp, input bit rst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coefficient <= CoefW'(coef);
    position <= PosW'(pos);
    component <= CompW'(comp);
    restart <= rst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted symbol has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Nonzero coefficient of a random size category, extremes now and then
  function automatic int random_coef();
    int unsigned sz;
    int mag;
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 2047 : -2048;
    sz = $urandom_range(11, 1);
    mag = $urandom_range((1 << sz) - 1, 1 << (sz - 1));
    return $urandom_range(1) ? mag : -mag;
  endfunction

  function automatic int any_coef();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // One block in zigzag order: dense, normal or sparse, with some noise requests
  task automatic send_block();
    int unsigned zero_pct;
    int unsigned comp;
    int pos;
    bit early_end;
    comp = $urandom_range(3);
    case ($urandom_range(2))
      0: zero_pct = 40;
      1: zero_pct = 80;
      default: zero_pct = 97;
    endcase
    early_end = (zero_pct != 97);
    send_coef(($urandom_range(4) == 0) ? 0 : any_coef(), 0, comp, $urandom_range(9) == 0);
    pos = 1;
    while (pos < BlockCoefs) begin
      if ($urandom_range(99) < 4) begin
        send_coef(any_coef(), $urandom_range(63), $urandom_range(3), $urandom_range(1));
      end else begin
        if (early_end && pos < LastPos && $urandom_range(99) < 5) pos = LastPos;
        send_coef(($urandom_range(99) < zero_pct) ? 0 : random_coef(), pos, comp, 1'b0);
        pos++;
      end
    end
  endtask

  // Zeros without an end of block, so the run saturates
  task automatic send_saturated_run();
    int unsigned comp;
    comp = $urandom_range(3);
    send_coef(any_coef(), 0, comp, 1'b0);
    repeat (70) send_coef(0, $urandom_range(LastPos - 1, 1), comp, 1'b0);
    send_coef(random_coef(), $urandom_range(LastPos - 1, 1), comp, 1'b0);
    send_coef(0, LastPos, comp, 1'b0);
  endtask

  task automatic run_phase();
    int unsigned phase_end;
    phase_end = items_sent + PhaseItems;
    while (items_sent < phase_end) send_block();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // DC extremes, widest difference, restart and zero difference
    send_coef(2047, 0, 0, 1'b1);
    send_coef(-2048, 0, 0, 1'b0);
    send_coef(-2048, 0, 1, 1'b1);
    send_coef(0, 0, 2, 1'b0);
    send_coef(5, 0, 3, 1'b0);
    send_coef(5, 0, 3, 1'b0);
    // AC extremes, short run, end of block
    send_coef(2047, 1, 3, 1'b0);
    send_coef(-2048, 2, 3, 1'b0);
    send_coef(1, 3, 3, 1'b0);
    send_coef(-1, 4, 3, 1'b0);
    send_coef(0, 5, 3, 1'b0);
    send_coef(0, 6, 3, 1'b0);
    send_coef(3, 7, 3, 1'b0);
    send_coef(0, LastPos, 3, 1'b0);
    // Nonzero at the last position, then out-of-order zeros into EOB
    send_coef(7, 0, 0, 1'b0);
    send_coef(-5, LastPos, 0, 1'b0);
    send_coef(0, 10, 0, 1'b0);
    send_coef(0, 12, 0, 1'b0);
    send_coef(0, LastPos, 0, 1'b0);
    // Restart on an AC request, then DC coded against zero
    send_coef(0, 4, 2, 1'b1);
    send_coef(3, 0, 1, 1'b0);
    // DC term clears a pending run
    send_coef(0, 1, 2, 1'b0);
    send_coef(0, 2, 2, 1'b0);
    send_coef(-7, 0, 2, 1'b0);
    send_coef(9, 1, 2, 1'b0);
    wait_drained();

    send_idle_pct = 8;
    recv_idle_pct = 54;
    run_phase();
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 8;
    run_phase();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_saturated_run();
    // Hold off the receiver while requests keep coming, then pause until drained
    long_hold_req <= 1'b1;
    send_block();
    wait_drained();
    run_phase();
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("** jpeg_run_length_symbol_coder_core: PASSED **");
    end else begin
      $display("** jpeg_run_length_symbol_coder_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
